// ===== design/mqlb_pkg.sv =====
// Shared types and constants for the multi-queue linked buffer.
package mqlb_pkg;

    localparam int DEF_POOL_DEPTH = 16;
    localparam int DEF_NUM_QUEUES = 8;
    localparam int DEF_DATA_WIDTH = 32;

    localparam int QID_W      = 3;
    localparam int DATA_IN_W  = 32;
    localparam int DATA_OUT_W = 32;
    localparam int S_TDATA_W  = 40;
    localparam int S_TUSER_W  = 1;
    localparam int M_TUSER_W  = 2;

    typedef enum logic {
        FUNC_ENQ = 1'b0,
        FUNC_DEQ = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // take an entry from / give an entry back to the free pool
    typedef struct packed {
        logic pop;
        logic push;
    } t_free_ctl;

endpackage

// ===== design/mqlb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mqlb_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/mqlb_free_list.sv =====
// Free entry pool: never-used entries from a counter, recycled ones from a FIFO.
module mqlb_free_list #(
    parameter int POOL_DEPTH = mqlb_pkg::DEF_POOL_DEPTH,
    parameter int AW         = $clog2(POOL_DEPTH),
    parameter int CW         = $clog2(POOL_DEPTH + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mqlb_pkg::t_free_ctl i_ctl,
    input  logic [AW-1:0]       i_push_idx,
    output logic [AW-1:0]       o_pop_idx
);

    localparam logic [AW-1:0] LAST_PTR = AW'(POOL_DEPTH - 1);

    logic [CW-1:0] r_fresh;
    logic [AW-1:0] r_rp;
    logic [AW-1:0] r_wp;
    logic          r_byp_valid;
    logic [AW-1:0] r_byp_idx;

    logic [CW-1:0] n_fresh;
    logic [AW-1:0] n_rp;
    logic [AW-1:0] n_wp;
    logic          n_byp_valid;

    logic          w_fresh_left;
    logic          w_pop_fifo;
    logic [AW-1:0] w_fifo_rdata;
    logic [AW-1:0] w_fifo_head;

    assign w_fresh_left = r_fresh < CW'(POOL_DEPTH);
    assign w_pop_fifo   = i_ctl.pop && !w_fresh_left;
    // write to the slot being read this cycle lands after the read; bypass it
    assign w_fifo_head  = r_byp_valid ? r_byp_idx : w_fifo_rdata;
    assign o_pop_idx    = w_fresh_left ? AW'(r_fresh) : w_fifo_head;

    always_comb begin
        n_fresh = r_fresh;
        n_rp    = r_rp;
        n_wp    = r_wp;
        if (i_ctl.pop && w_fresh_left) begin
            n_fresh = r_fresh + CW'(1);
        end
        if (w_pop_fifo) begin
            n_rp = (r_rp == LAST_PTR) ? '0 : r_rp + AW'(1);
        end
        if (i_ctl.push) begin
            n_wp = (r_wp == LAST_PTR) ? '0 : r_wp + AW'(1);
        end
        n_byp_valid = i_ctl.push && (r_wp == n_rp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fresh     <= '0;
            r_rp        <= '0;
            r_wp        <= '0;
            r_byp_valid <= 1'b0;
        end else begin
            r_fresh     <= n_fresh;
            r_rp        <= n_rp;
            r_wp        <= n_wp;
            r_byp_valid <= n_byp_valid;
        end
        r_byp_idx <= i_push_idx;
    end

    mqlb_ram #(
        .WIDTH  (AW),
        .DEPTH  (POOL_DEPTH),
        .ADDR_W (AW)
    ) u_fifo_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_ctl.push),
        .i_wr_addr (r_wp),
        .i_wr_data (i_push_idx),
        .i_rd_en   (1'b1),
        .i_rd_addr (n_rp),
        .o_rd_data (w_fifo_rdata)
    );

endmodule

// ===== design/multi_queue_linked_buffer_core.sv =====
// Top level: several FIFO queues kept as linked chains in one shared entry pool.
// Path: an accepted input beat is held in the input register, and its result in the result
// register, from which the result handshake is made.
// Throughput: one beat per cycle unless the result is stalled; a dequeue's next-head link is
// forwarded from the link RAM read port so back-to-back operations on one queue keep full rate.
// Reset (synchronous): all queues empty, whole pool free; no RAM clearing pass.
module multi_queue_linked_buffer_core #(
    parameter int POOL_DEPTH = mqlb_pkg::DEF_POOL_DEPTH,
    parameter int NUM_QUEUES = mqlb_pkg::DEF_NUM_QUEUES,
    parameter int DATA_WIDTH = mqlb_pkg::DEF_DATA_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [mqlb_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // queue_id[2:0], data[34:3]
    input  logic [mqlb_pkg::S_TUSER_W-1:0]     s_axis_tuser,  // func[0]
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [mqlb_pkg::DATA_OUT_W-1:0]    m_axis_tdata,  // data_out[31:0]
    output logic [mqlb_pkg::M_TUSER_W-1:0]     m_axis_tuser   // status[1:0]
);

    localparam int AW  = $clog2(POOL_DEPTH);
    localparam int CW  = $clog2(POOL_DEPTH + 1);
    localparam int QIW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

    // input register
    logic                          r_in_valid;
    mqlb_pkg::t_func               r_in_func;
    logic [mqlb_pkg::QID_W-1:0]    r_in_qid;
    logic [DATA_WIDTH-1:0]         r_in_data;

    // queue state
    logic [AW-1:0]         r_head [NUM_QUEUES];
    logic [AW-1:0]         r_tail [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] r_nonempty;
    logic [CW-1:0]         r_free_count;
    logic                  r_pend_valid;
    logic [QIW-1:0]        r_pend_q;

    logic [AW-1:0]         n_head [NUM_QUEUES];
    logic [AW-1:0]         n_tail [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] n_nonempty;
    logic [CW-1:0]         n_free_count;
    logic                  n_pend_valid;

    // result register
    logic                  r_out_valid;
    mqlb_pkg::t_status     r_out_status;
    logic                  r_out_take;

    logic                  w_commit;
    logic                  w_q_ok;
    logic [QIW-1:0]        w_qi;
    logic [AW-1:0]         w_head_q;
    logic [AW-1:0]         w_tail_q;
    logic                  w_ne_q;
    logic                  w_enq_ok;
    logic                  w_deq_ok;
    mqlb_pkg::t_status     w_status;
    logic [AW-1:0]         w_alloc;
    logic [AW-1:0]         w_link_rdata;
    logic [DATA_WIDTH-1:0] w_data_rdata;
    mqlb_pkg::t_free_ctl   w_free_ctl;

    assign w_commit      = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_commit;

    assign w_q_ok   = 32'(r_in_qid) < 32'(NUM_QUEUES);
    assign w_qi     = QIW'(r_in_qid);
    // head of a queue dequeued last cycle is still in flight from the link RAM
    assign w_head_q = (r_pend_valid && r_pend_q == w_qi) ? w_link_rdata : r_head[w_qi];
    assign w_tail_q = r_tail[w_qi];
    assign w_ne_q   = r_nonempty[w_qi];

    always_comb begin
        w_enq_ok = 1'b0;
        w_deq_ok = 1'b0;
        w_status = mqlb_pkg::ST_OK;
        unique case (r_in_func)
            mqlb_pkg::FUNC_ENQ: begin
                w_enq_ok = w_q_ok && (r_free_count != '0);
                w_status = w_enq_ok ? mqlb_pkg::ST_OK : mqlb_pkg::ST_FULL;
            end
            mqlb_pkg::FUNC_DEQ: begin
                w_deq_ok = w_q_ok && w_ne_q;
                w_status = w_deq_ok ? mqlb_pkg::ST_OK : mqlb_pkg::ST_EMPTY;
            end
            default: begin
                w_status = mqlb_pkg::ST_OK;
            end
        endcase
    end

    assign w_free_ctl.pop  = w_commit && w_enq_ok;
    assign w_free_ctl.push = w_commit && w_deq_ok;

    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_nonempty   = r_nonempty;
        n_free_count = r_free_count;
        n_pend_valid = 1'b0;
        if (r_pend_valid) begin
            n_head[r_pend_q] = w_link_rdata;
        end
        if (w_commit && w_enq_ok) begin
            n_tail[w_qi]  = w_alloc;
            n_free_count  = r_free_count - CW'(1);
            if (!w_ne_q) begin
                n_head[w_qi]     = w_alloc;
                n_nonempty[w_qi] = 1'b1;
            end
        end
        if (w_commit && w_deq_ok) begin
            if (w_head_q == w_tail_q) begin
                n_nonempty[w_qi] = 1'b0;
            end else begin
                n_pend_valid = 1'b1;
            end
            if (r_free_count < CW'(POOL_DEPTH)) begin
                n_free_count = r_free_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_nonempty   <= '0;
            r_free_count <= CW'(POOL_DEPTH);
            r_pend_valid <= 1'b0;
            r_pend_q     <= '0;
            r_out_valid  <= 1'b0;
            r_out_status <= mqlb_pkg::ST_OK;
            r_out_take   <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
            end
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_nonempty   <= n_nonempty;
            r_free_count <= n_free_count;
            r_pend_valid <= n_pend_valid;
            if (n_pend_valid) begin
                r_pend_q <= w_qi;
            end
            if (w_commit) begin
                r_out_valid  <= 1'b1;
                r_out_status <= w_status;
                r_out_take   <= w_deq_ok;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // input payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_func <= mqlb_pkg::t_func'(s_axis_tuser[0]);
            r_in_qid  <= s_axis_tdata[mqlb_pkg::QID_W-1:0];
            r_in_data <= DATA_WIDTH'(s_axis_tdata[mqlb_pkg::QID_W +: mqlb_pkg::DATA_IN_W]);
        end
    end

    mqlb_free_list #(
        .POOL_DEPTH (POOL_DEPTH),
        .AW         (AW),
        .CW         (CW)
    ) u_free_list (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_free_ctl),
        .i_push_idx (w_head_q),
        .o_pop_idx  (w_alloc)
    );

    mqlb_ram #(
        .WIDTH  (AW),
        .DEPTH  (POOL_DEPTH),
        .ADDR_W (AW)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_commit && w_enq_ok && w_ne_q),
        .i_wr_addr (w_tail_q),
        .i_wr_data (w_alloc),
        .i_rd_en   (w_commit && w_deq_ok),
        .i_rd_addr (w_head_q),
        .o_rd_data (w_link_rdata)
    );

    mqlb_ram #(
        .WIDTH  (DATA_WIDTH),
        .DEPTH  (POOL_DEPTH),
        .ADDR_W (AW)
    ) u_data_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_commit && w_enq_ok),
        .i_wr_addr (w_alloc),
        .i_wr_data (r_in_data),
        .i_rd_en   (w_commit && w_deq_ok),
        .i_rd_addr (w_head_q),
        .o_rd_data (w_data_rdata)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_take ? mqlb_pkg::DATA_OUT_W'(w_data_rdata) : '0;
    assign m_axis_tuser  = r_out_status;

`ifndef NO_ASSERTIONS
    a_free_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_count <= CW'(POOL_DEPTH))
        else $error("free count above pool depth");

    a_pend_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> r_nonempty[r_pend_q])
        else $error("pending head fix on an empty queue");

    a_data_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |=> $stable(w_data_rdata))
        else $error("dequeued data changed while result stalled");

    a_enq_sets_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit && w_enq_ok |=> r_nonempty[$past(w_qi)])
        else $error("queue empty after successful enqueue");
`endif

endmodule
